### rtl/rspa_pkg.sv
package rspa_pkg;

    // default pool size
    localparam int POOL_SLOTS_DEF = 1024;

    // busy bitmap word layout
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);

    // port field widths
    localparam int REL_W   = 11;
    localparam int GRANT_W = 10;
    localparam int FREE_W  = 11;

    // operation codes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // word search result
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } search_res_t;

endpackage

### rtl/rspa_ram.sv
module rspa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rspa_word_search.sv
module rspa_word_search (
    input  logic [rspa_pkg::WORD_W-1:0] data,
    input  logic [rspa_pkg::WORD_W-1:0] mask,
    output rspa_pkg::search_res_t       res
);

    logic [rspa_pkg::WORD_W-1:0] cand;

    // candidate bits are free slots inside the mask
    assign cand = ~data & mask;

    // lowest candidate wins
    always_comb
    begin
        res = '0;
        for (int i = rspa_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                res.found   = 1'b1;
                res.bit_idx = rspa_pkg::BIT_W'(i);
            end
        end
    end

endmodule

### rtl/rotating_slot_pool_allocator.sv
// Rotating slot pool allocator.
// Command channel: start, operation, release_slot. A command is taken at a
// rising edge where start is high and busy is low. operation selects acquire
// (first free slot at or after the rotating pointer) or release of one slot.
// Result channel: done pulses for one cycle with status, granted_slot and
// free_slots valid in that same cycle; the receiver must take it then, it
// cannot hold results off.
// Exhausted acquires and out-of-range releases are answered straight from
// idle; a release reads the slot's bitmap word, then clears its bit if set; an
// acquire reads bitmap words from the pointer word on until one holds a free
// slot. busy is high while a release or a granted acquire is served and falls
// as done rises, so one command is in flight at a time. The busy bitmap sits
// in a 32-bit wide RAM that one word search unit reads one word per cycle.
// Reset: busy is held high during a clearing pass that zeroes every bitmap
// word; afterwards every slot is free, the pointer is zero and the free count
// is POOL_SLOTS.
module rotating_slot_pool_allocator #(
    parameter int POOL_SLOTS = rspa_pkg::POOL_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [rspa_pkg::REL_W-1:0]   release_slot,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [rspa_pkg::GRANT_W-1:0] granted_slot,
    output logic [rspa_pkg::FREE_W-1:0]  free_slots
);

    localparam int WORD_W    = rspa_pkg::WORD_W;
    localparam int BIT_W     = rspa_pkg::BIT_W;
    localparam int SLOT_W    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W     = $clog2(POOL_SLOTS + 1);
    localparam int NWORDS    = (POOL_SLOTS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LAST_BITS = POOL_SLOTS - (NWORDS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_MASK =
        (LAST_BITS == WORD_W) ? '1 : WORD_W'((64'd1 << LAST_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NWORDS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE
    } state_t;

    state_t                   state_reg, state_next;
    logic [ADDR_W-1:0]        clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]        ptr_reg, ptr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [ADDR_W-1:0]        scan_word_reg, scan_word_next;
    logic                     first_reg, first_next;
    logic                     done_reg, done_next;
    rspa_pkg::status_t        status_reg, status_next;
    logic [rspa_pkg::GRANT_W-1:0] granted_reg, granted_next;
    logic [rspa_pkg::FREE_W-1:0]  free_reg, free_next;

    logic                     accept;
    logic [31:0]              ptr_ext;
    logic [ADDR_W-1:0]        ptr_word;
    logic [BIT_W-1:0]         ptr_bit;
    logic [31:0]              rel_ext;
    logic                     rel_ok;
    logic [31:0]              slot_ext;
    logic [ADDR_W-1:0]        slot_word;
    logic [BIT_W-1:0]         slot_bit;
    logic [WORD_W-1:0]        scan_mask;
    logic [ADDR_W-1:0]        scan_word_inc;
    logic [31:0]              found_ext;
    logic [SLOT_W-1:0]        found_slot;
    logic [31:0]              cnt_ext;
    logic [31:0]              grant_ext;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [WORD_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [WORD_W-1:0]        ram_rdata;
    rspa_pkg::search_res_t    res;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // pointer and release index split into word and bit
    assign ptr_ext   = 32'(ptr_reg);
    assign ptr_word  = ADDR_W'(ptr_ext >> BIT_W);
    assign ptr_bit   = ptr_ext[BIT_W-1:0];
    assign rel_ext   = 32'(release_slot);
    assign rel_ok    = (rel_ext < 32'(POOL_SLOTS));
    assign slot_ext  = 32'(slot_reg);
    assign slot_word = ADDR_W'(slot_ext >> BIT_W);
    assign slot_bit  = slot_ext[BIT_W-1:0];

    // first word starts at the pointer bit, the last word stops at the pool end
    always_comb
    begin
        scan_mask = first_reg ? ({WORD_W{1'b1}} << ptr_bit) : {WORD_W{1'b1}};
        if (scan_word_reg == LAST_WORD)
        begin
            scan_mask = scan_mask & LAST_MASK;
        end
    end

    assign scan_word_inc = (scan_word_reg == LAST_WORD) ? '0 : scan_word_reg + 1'b1;
    assign found_ext     = (32'(scan_word_reg) << BIT_W) | 32'(res.bit_idx);
    assign found_slot    = SLOT_W'(found_ext);

    // busy bitmap
    rspa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // word search unit for the acquire scan
    rspa_word_search u_search (
        .data (ram_rdata),
        .mask (scan_mask),
        .res  (res)
    );

    // sequencer next state, ram control and result values
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        scan_word_next = scan_word_reg;
        first_next     = first_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        granted_next   = granted_reg;
        ram_we         = 1'b0;
        ram_waddr      = scan_word_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = scan_word_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (operation == rspa_pkg::OP_ACQUIRE)
                begin
                    ram_raddr = ptr_word;
                end
                else
                begin
                    ram_raddr = ADDR_W'(rel_ext >> BIT_W);
                end
                if (accept)
                begin
                    granted_next = '0;
                    if (operation == rspa_pkg::OP_ACQUIRE)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = rspa_pkg::ST_EXHAUSTED;
                        end
                        else
                        begin
                            state_next     = S_SCAN;
                            scan_word_next = ptr_word;
                            first_next     = 1'b1;
                        end
                    end
                    else if (!rel_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = rspa_pkg::ST_BAD_INDEX;
                    end
                    else
                    begin
                        state_next = S_FREE;
                        slot_next  = SLOT_W'(rel_ext);
                    end
                end
            end
            S_SCAN:
            begin
                if (res.found)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = scan_word_reg;
                    ram_wdata    = ram_rdata | (WORD_W'(1) << res.bit_idx);
                    count_next   = count_reg - 1'b1;
                    ptr_next     = (found_slot == LAST_SLOT) ? '0 : found_slot + 1'b1;
                    done_next    = 1'b1;
                    status_next  = rspa_pkg::ST_GRANTED;
                    granted_next = rspa_pkg::GRANT_W'(found_ext);
                    state_next   = S_IDLE;
                end
                else
                begin
                    // fetch the next word, wrapping at the pool end
                    ram_raddr      = scan_word_inc;
                    scan_word_next = scan_word_inc;
                    first_next     = 1'b0;
                end
            end
            S_FREE:
            begin
                if (ram_rdata[slot_bit])
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_word;
                    ram_wdata  = ram_rdata & ~(WORD_W'(1) << slot_bit);
                    count_next = count_reg + 1'b1;
                end
                done_next   = 1'b1;
                status_next = rspa_pkg::ST_RELEASED;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cnt_ext   = 32'(count_next);
    assign free_next = cnt_ext[rspa_pkg::FREE_W-1:0];
    assign grant_ext = 32'(granted_reg);

    // state, counters and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            ptr_reg      <= '0;
            count_reg    <= CNT_W'(POOL_SLOTS);
            done_reg     <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            ptr_reg      <= ptr_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            first_reg    <= first_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        scan_word_reg <= scan_word_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        if (done_next)
        begin
            free_reg <= free_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = grant_ext[rspa_pkg::GRANT_W-1:0];
    assign free_slots   = free_reg;

`ifndef ASSERT_OFF
    // free count never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(POOL_SLOTS))
        else $error("free count above pool size");

    // a grant takes exactly one slot from the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == rspa_pkg::ST_GRANTED)
            |-> (count_reg + CNT_W'(1)) == $past(count_reg))
        else $error("grant did not decrement free count");

    // exhaustion is reported only with no free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == rspa_pkg::ST_EXHAUSTED) |-> count_reg == '0)
        else $error("exhausted reported with free slots");

    // a scan never runs with an empty pool
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> count_reg != '0)
        else $error("scan started on empty pool");
`endif

endmodule

### tb/slot_pool_checker.sv
module slot_pool_checker #(
    parameter int POOL_SLOTS = rspa_pkg::POOL_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         operation,
    input  logic [rspa_pkg::REL_W-1:0]   release_slot,
    input  logic                         done,
    input  logic [1:0]                   status,
    input  logic [rspa_pkg::GRANT_W-1:0] granted_slot,
    input  logic [rspa_pkg::FREE_W-1:0]  free_slots,
    output int                           mismatch_count,
    output int                           pending_count
);

    typedef struct packed {
        rspa_pkg::status_t                status;
        logic [rspa_pkg::GRANT_W-1:0]     slot;
        logic [rspa_pkg::FREE_W-1:0]      free;
    } alloc_result_t;

    // shadow of the pool: one flag per slot, rotating pointer, free count
    bit            slot_used [POOL_SLOTS];
    int unsigned   scan_ptr;
    int unsigned   free_count;
    alloc_result_t pool_answers [$];
    int            errors;

    // apply one command to the shadow pool and return the answer it gives
    function automatic alloc_result_t pool_update(
        logic                       op,
        logic [rspa_pkg::REL_W-1:0] idx
    );
        alloc_result_t r;
        int unsigned   probe;
        bit            found;
        r.status = rspa_pkg::ST_EXHAUSTED;
        r.slot   = '0;
        found    = 1'b0;
        if (op == rspa_pkg::OP_ACQUIRE)
        begin
            // first free slot at or after the pointer, wrapping
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                probe = (scan_ptr + i) % POOL_SLOTS;
                if (!found && !slot_used[probe])
                begin
                    found            = 1'b1;
                    slot_used[probe] = 1'b1;
                    free_count       = free_count - 1;
                    scan_ptr         = (probe + 1) % POOL_SLOTS;
                    r.status         = rspa_pkg::ST_GRANTED;
                    r.slot           = probe[rspa_pkg::GRANT_W-1:0];
                end
            end
        end
        else if (idx >= POOL_SLOTS)
        begin
            r.status = rspa_pkg::ST_BAD_INDEX;
        end
        else
        begin
            // freeing an already free slot leaves the count alone
            if (slot_used[idx])
            begin
                slot_used[idx] = 1'b0;
                free_count     = free_count + 1;
            end
            r.status = rspa_pkg::ST_RELEASED;
        end
        r.free = free_count[rspa_pkg::FREE_W-1:0];
        return r;
    endfunction

    // compare each result transfer, then predict each command transfer
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            scan_ptr   = 0;
            free_count = POOL_SLOTS;
            pool_answers.delete();
            errors          = 0;
            pending_count  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pool_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result status=%0d slot=%0d free=%0d",
                             $time, status, granted_slot, free_slots);
                end
                else
                begin
                    want = pool_answers.pop_front();
                    if (status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                    if (granted_slot !== want.slot)
                    begin
                        errors++;
                        $display("%0t: granted_slot expected %0d actual %0d",
                                 $time, want.slot, granted_slot);
                    end
                    if (free_slots !== want.free)
                    begin
                        errors++;
                        $display("%0t: free_slots expected %0d actual %0d",
                                 $time, want.free, free_slots);
                    end
                end
            end
            if (start && !busy)
                pool_answers.insert(pool_answers.size(),
                                    pool_update(operation, release_slot));
            pending_count  <= pool_answers.size();
            mismatch_count <= errors;
        end
    end

endmodule

### tb/rotating_slot_pool_allocator_tb.sv
module rotating_slot_pool_allocator_tb;

    localparam int POOL_SLOTS = rspa_pkg::POOL_SLOTS_DEF;
    localparam int TAIL_CYCLES = POOL_SLOTS / 32 + 8;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         operation;
    logic [rspa_pkg::REL_W-1:0]   release_slot;
    logic                         done;
    logic [1:0]                   status;
    logic [rspa_pkg::GRANT_W-1:0] granted_slot;
    logic [rspa_pkg::FREE_W-1:0]  free_slots;
    int                           mismatch_count;
    int                           pending_count;
    int                           idle_pct;

    rotating_slot_pool_allocator #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .release_slot(release_slot),
        .done(done),
        .status(status),
        .granted_slot(granted_slot),
        .free_slots(free_slots)
    );

    slot_pool_checker #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .release_slot(release_slot),
        .done(done),
        .status(status),
        .granted_slot(granted_slot),
        .free_slots(free_slots),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // one command transfer, with optional idle cycles ahead of it
    task automatic send_command(logic op, logic [rspa_pkg::REL_W-1:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        release_slot <= idx;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random command: acquire with the given odds, else mostly in-range release
    task automatic random_command(int acquire_pct);
        int pick;
        pick = $urandom_range(9);
        if ($urandom_range(99) < acquire_pct)
            send_command(rspa_pkg::OP_ACQUIRE, rspa_pkg::REL_W'($urandom_range(2047)));
        else if (pick < 8)
            send_command(rspa_pkg::OP_RELEASE,
                         rspa_pkg::REL_W'($urandom_range(POOL_SLOTS - 1)));
        else if (pick == 8)
            send_command(rspa_pkg::OP_RELEASE,
                         rspa_pkg::REL_W'($urandom_range(2047, POOL_SLOTS)));
        else
            send_command(rspa_pkg::OP_RELEASE, rspa_pkg::REL_W'($urandom_range(2047)));
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = rspa_pkg::OP_ACQUIRE;
        release_slot = '0;
        idle_pct     = 18;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: grants from reset, releases of busy/free/out-of-range slots
        send_command(rspa_pkg::OP_ACQUIRE, 11'd0);
        send_command(rspa_pkg::OP_ACQUIRE, 11'd2047);
        send_command(rspa_pkg::OP_RELEASE, 11'd0);
        send_command(rspa_pkg::OP_RELEASE, 11'd0);
        send_command(rspa_pkg::OP_RELEASE, rspa_pkg::REL_W'(POOL_SLOTS));
        send_command(rspa_pkg::OP_RELEASE, 11'd2047);
        send_command(rspa_pkg::OP_RELEASE, rspa_pkg::REL_W'(POOL_SLOTS - 1));
        send_command(rspa_pkg::OP_ACQUIRE, 11'd1365);
        send_command(rspa_pkg::OP_RELEASE, 11'd1365);
        send_command(rspa_pkg::OP_RELEASE, 11'd682);
        send_command(rspa_pkg::OP_RELEASE, 11'd1);
        send_command(rspa_pkg::OP_RELEASE, 11'd2);
        send_command(rspa_pkg::OP_ACQUIRE, 11'd682);
        send_command(rspa_pkg::OP_ACQUIRE, 11'd0);
        wait_drained();

        // fill the pool mostly with acquires, sender idling lightly
        repeat (500) random_command(90);
        wait_drained();

        // keep filling with a sluggish sender
        idle_pct = 72;
        repeat (500) random_command(97);
        wait_drained();

        // back to back: wrap and exhaust, churn at full, then drain down
        idle_pct = 0;
        repeat (200)
            send_command(rspa_pkg::OP_ACQUIRE, rspa_pkg::REL_W'($urandom_range(2047)));
        repeat (100) random_command(85);
        repeat (250) random_command(25);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/rspa_pkg.sv
rtl/rspa_ram.sv
rtl/rspa_word_search.sv
rtl/rotating_slot_pool_allocator.sv
tb/slot_pool_checker.sv
tb/rotating_slot_pool_allocator_tb.sv
